### hw/rtl/bcfd_pkg.sv
package bcfd_pkg;

  // Frame body layout, counted from the CRC end of the frame
  localparam int unsigned BodyBits   = 43;
  localparam int unsigned CrcBits    = 6;
  localparam int unsigned CrcSpanBits = 37;  // ack down to warn
  localparam int unsigned PosBits    = 32;
  localparam int unsigned PosLsb     = 8;
  localparam int unsigned ErrBit     = 7;
  localparam int unsigned WarnBit    = 6;

  // CRC6: x^6 + x + 1, preset all ones, inverted at the end
  localparam logic [CrcBits-1:0] CrcPoly = 6'h03;
  localparam logic [CrcBits-1:0] CrcInit = 6'h3F;

  // Result beat width: 76 bits of fields padded to whole bytes
  localparam int unsigned ResultBits = 80;

  typedef struct packed {
    logic                 ack_bit;
    logic                 start_flag;
    logic                 cds_bit;
    logic [PosBits-1:0]   position;
    logic                 error_flag;
    logic                 warn_flag;
    logic [CrcBits-1:0]   crc_received;
    logic                 crc_good;
    logic [PosBits-1:0]   held_position;
  } result_t;

  // Bitwise CRC6 over the span, MSB first; unrolls to an XOR network
  function automatic logic [CrcBits-1:0] crc6(input logic [CrcSpanBits-1:0] span);
    logic [CrcBits-1:0] crc;
    logic               fb;
    crc = CrcInit;
    for (int i = CrcSpanBits - 1; i >= 0; i--) begin
      fb  = span[i] ^ crc[CrcBits-1];
      crc = {crc[CrcBits-2:0], 1'b0};
      if (fb) begin
        crc = crc ^ CrcPoly;
      end
    end
    return ~crc;
  endfunction

endpackage

### hw/rtl/bcfd_assembler.sv
module bcfd_assembler #(
  parameter int unsigned FRAME_BYTES = 6
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     byte_valid_i,
  output logic                     byte_ready_o,
  input  logic [7:0]               byte_i,
  output logic                     frame_valid_o,
  input  logic                     frame_ready_i,
  output logic [8*FRAME_BYTES-1:0] frame_o
);

  localparam int unsigned FrameW  = 8 * FRAME_BYTES;
  localparam int unsigned CntW    = $clog2(FRAME_BYTES);
  localparam logic [CntW-1:0] LastCnt = CntW'(FRAME_BYTES - 1);

  logic [FrameW-1:0] frame_q, frame_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              frm_valid_q, frm_valid_d;
  logic              accept;
  logic              last_byte;

  // A completed frame may be replaced in the same cycle it moves on
  assign byte_ready_o  = ~frm_valid_q | frame_ready_i;
  assign accept        = byte_valid_i & byte_ready_o;
  assign last_byte     = (cnt_q == LastCnt);
  assign frame_valid_o = frm_valid_q;
  assign frame_o       = frame_q;

  // Shift register and byte counter
  always_comb begin
    frame_d     = frame_q;
    cnt_d       = cnt_q;
    frm_valid_d = frm_valid_q & ~frame_ready_i;
    if (accept) begin
      frame_d = {frame_q[FrameW-9:0], byte_i};
      if (last_byte) begin
        cnt_d       = '0;
        frm_valid_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      frm_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      frm_valid_q <= frm_valid_d;
    end
  end

  // Frame bytes are all rewritten before a frame is flagged
  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
  end

endmodule

### hw/rtl/bcfd_checker.sv
module bcfd_checker #(
  parameter int unsigned FRAME_BYTES       = 6,
  parameter int unsigned FRAME_LENGTH_BITS = 43
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     frame_valid_i,
  output logic                     frame_ready_o,
  input  logic [8*FRAME_BYTES-1:0] frame_i,
  output logic                     result_valid_o,
  input  logic                     result_ready_i,
  output bcfd_pkg::result_t        result_o
);

  localparam int unsigned FrameW = 8 * FRAME_BYTES;
  localparam int unsigned Drop   = FrameW - FRAME_LENGTH_BITS;

  logic [bcfd_pkg::BodyBits-1:0] body;
  logic [bcfd_pkg::PosBits-1:0]  pos;
  logic [bcfd_pkg::CrcBits-1:0]  crc_rx;
  logic                          good;
  logic                          load;

  bcfd_pkg::result_t             res_q, res_d;
  logic                          out_valid_q, out_valid_d;
  logic [bcfd_pkg::PosBits-1:0]  held_q, held_d;

  // Trailing bits are dropped; the body sits just above them
  assign body   = frame_i[Drop +: bcfd_pkg::BodyBits];
  assign pos    = body[bcfd_pkg::PosLsb +: bcfd_pkg::PosBits];
  assign crc_rx = body[bcfd_pkg::CrcBits-1:0];
  assign good   = (bcfd_pkg::crc6(body[bcfd_pkg::BodyBits-1:bcfd_pkg::CrcBits]) == crc_rx);

  assign frame_ready_o  = ~out_valid_q | result_ready_i;
  assign load           = frame_valid_i & frame_ready_o;
  assign result_valid_o = out_valid_q;
  assign result_o       = res_q;

  // Field extraction and held position
  always_comb begin
    held_d = held_q;
    if (load && good) begin
      held_d = pos;
    end
    res_d.ack_bit       = frame_i[FrameW-1];
    res_d.start_flag    = frame_i[FrameW-2];
    res_d.cds_bit       = frame_i[FrameW-3];
    res_d.position      = pos;
    res_d.error_flag    = body[bcfd_pkg::ErrBit];
    res_d.warn_flag     = body[bcfd_pkg::WarnBit];
    res_d.crc_received  = crc_rx;
    res_d.crc_good      = good;
    res_d.held_position = good ? pos : held_q;
    out_valid_d = load | (out_valid_q & ~result_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      held_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      held_q      <= held_d;
    end
  end

  // Result register loads only when a frame moves in
  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

endmodule

### hw/rtl/biss_c_frame_decoder.sv
// BiSS-C position frame decoder.
// Slave stream: one received encoder byte per beat, most significant byte
// of the frame first. Every FRAME_BYTES-th byte closes a frame; the
// trailing 8*FRAME_BYTES - FRAME_LENGTH_BITS bits are dropped.
// Master stream: one result beat per frame with the decoded fields, the
// CRC6 check (x^6 + x + 1, preset ones, inverted) and the position of the
// most recent frame with a good CRC, this frame included.
// Throughput: one byte per cycle while the result stream does not stall.
// The edge that takes the closing byte writes the frame register; CRC and
// extraction then feed the result register, which holds the result beat.
// Reset clears the byte counter, the held position and both valid flags;
// the next byte starts a new frame.
// When the receiver stalls, the result register holds its beat and one
// more completed frame waits in the frame register; s_axis_tready stays
// low while that frame cannot move on.
module biss_c_frame_decoder #(
  parameter int unsigned FRAME_BYTES       = 6,
  parameter int unsigned FRAME_LENGTH_BITS = 43
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,   // [7:0] rx_byte
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] ack_bit, [1] start_flag, [2] cds_bit, [34:3] position,
  // [35] error_flag, [36] warn_flag, [42:37] crc_received,
  // [43] crc_good, [75:44] held_position, [79:76] zero
  output logic [bcfd_pkg::ResultBits-1:0]     m_axis_tdata
);

  logic                     frame_valid;
  logic                     frame_ready;
  logic [8*FRAME_BYTES-1:0] frame;
  bcfd_pkg::result_t        res;

  bcfd_assembler #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_assembler (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_valid_i  (s_axis_tvalid),
    .byte_ready_o  (s_axis_tready),
    .byte_i        (s_axis_tdata),
    .frame_valid_o (frame_valid),
    .frame_ready_i (frame_ready),
    .frame_o       (frame)
  );

  bcfd_checker #(
    .FRAME_BYTES       (FRAME_BYTES),
    .FRAME_LENGTH_BITS (FRAME_LENGTH_BITS)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .frame_valid_i  (frame_valid),
    .frame_ready_o  (frame_ready),
    .frame_i        (frame),
    .result_valid_o (m_axis_tvalid),
    .result_ready_i (m_axis_tready),
    .result_o       (res)
  );

  // Pack result fields, first field lowest
  assign m_axis_tdata = {4'b0000, res.held_position, res.crc_good, res.crc_received,
                         res.warn_flag, res.error_flag, res.position,
                         res.cds_bit, res.start_flag, res.ack_bit};

  // A good frame reports its own position as the held one
  a_good_holds_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[43]) |-> (m_axis_tdata[75:44] == m_axis_tdata[34:3]))
    else $error("held position differs from position of a good frame");

  // A blocked frame stays pending
  a_frame_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_valid && !frame_ready) |=> frame_valid)
    else $error("pending frame lost while checker was busy");

  // No byte is taken while a pending frame cannot move on
  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_valid && !frame_ready) |-> !s_axis_tready)
    else $error("byte accepted over a blocked frame");

  // The checker only frees up when the result register drains
  a_ready_link : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !frame_ready)
    else $error("checker ready while result is stalled");

endmodule
